>>> src/gjk_simplex_refine_core_defines.svh
// assertion macros shared by the gjk simplex refine core
`ifndef GJK_SIMPLEX_REFINE_CORE_DEFINES_SVH
`define GJK_SIMPLEX_REFINE_CORE_DEFINES_SVH

// checked at every rising edge outside reset
`define GJKSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising edge, reset included
`define GJKSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/gjksr_pkg.sv
// types, constants and the product schedule of the gjk simplex refine core
`default_nettype none

package gjksr_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIR_W   = 52;
  localparam int unsigned WIDE_W  = 54;
  localparam int unsigned NAR_W   = 18;
  localparam int unsigned PART_W  = 27;
  localparam int unsigned PROD_W  = PART_W + 1 + NAR_W;
  localparam int unsigned ACC_W   = 74;
  localparam int unsigned IT_W    = 8;
  localparam int unsigned CNT_W   = 3;

  localparam logic [IT_W-1:0] MAX_IT_RESET = 8'd32;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  localparam logic [1:0] ST_CONT    = 2'd0;
  localparam logic [1:0] ST_HIT     = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] point_t;
  typedef logic signed [NAR_W-1:0] nar_t;
  typedef nar_t [2:0] nar_vec_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef wide_t [2:0] wide_vec_t;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } req_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [1:0]              status;
    logic [CNT_W-1:0]        simplex_count;
  } rsp_t;

  typedef enum logic {VU_DOT, VU_CROSS} vu_kind_t;

  typedef struct packed {
    logic     start;
    vu_kind_t kind;
    logic     neg;
  } vu_ctrl_t;

  typedef struct packed {
    logic done;
    logic pos;
  } vu_stat_t;

  typedef struct packed {
    logic [1:0] ui;
    logic [1:0] vi;
    logic       sub;
  } term_t;

  // operand indexes of one product term
  function automatic term_t term_sel(vu_kind_t kind, logic [2:0] t);
    term_t r;
    r.ui  = 2'd0;
    r.vi  = 2'd0;
    r.sub = 1'b0;
    if (kind == VU_DOT) begin
      r.ui = t[1:0];
      r.vi = t[1:0];
    end else begin
      unique case (t)
        3'd0: begin r.ui = 2'd1; r.vi = 2'd2; r.sub = 1'b0; end
        3'd1: begin r.ui = 2'd2; r.vi = 2'd1; r.sub = 1'b1; end
        3'd2: begin r.ui = 2'd2; r.vi = 2'd0; r.sub = 1'b0; end
        3'd3: begin r.ui = 2'd0; r.vi = 2'd2; r.sub = 1'b1; end
        3'd4: begin r.ui = 2'd0; r.vi = 2'd1; r.sub = 1'b0; end
        3'd5: begin r.ui = 2'd1; r.vi = 2'd0; r.sub = 1'b1; end
        default: begin r.ui = 2'd0; r.vi = 2'd0; r.sub = 1'b0; end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/gjksr_vec_unit.sv
// shared multiply-accumulate unit for cross and dot products
`default_nettype none

module gjksr_vec_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  gjksr_pkg::vu_ctrl_t   ctrl,
  input  gjksr_pkg::wide_vec_t  u,
  input  gjksr_pkg::nar_vec_t   v,
  output gjksr_pkg::vu_stat_t   stat,
  output gjksr_pkg::wide_vec_t  res
);

  localparam logic [3:0] LAST_CROSS = 4'd11;
  localparam logic [3:0] LAST_DOT   = 4'd5;

  logic                      busy;
  gjksr_pkg::vu_kind_t       kind_r;
  logic                      neg_r;
  logic [3:0]                step;

  logic                      p_valid;
  logic                      p_first;
  logic                      p_last;
  logic                      p_final;
  logic                      p_shift;
  logic                      p_sub;
  logic [1:0]                p_comp;
  logic signed [gjksr_pkg::PROD_W-1:0] p_prod;

  logic signed [gjksr_pkg::ACC_W-1:0] acc;
  logic                      done_r;
  logic                      pos_r;
  gjksr_pkg::wide_vec_t      res_r;

  // issue side
  logic [2:0]                term;
  logic                      half;
  gjksr_pkg::term_t          sel;
  gjksr_pkg::wide_t          u_sel;
  logic signed [gjksr_pkg::PART_W:0] part;
  logic signed [gjksr_pkg::PROD_W-1:0] prod_next;
  logic                      g_first;
  logic                      g_last;
  logic                      g_final;
  logic                      is_last_step;

  // accumulate side
  logic signed [gjksr_pkg::ACC_W-1:0] ext;
  logic signed [gjksr_pkg::ACC_W-1:0] addend;
  logic signed [gjksr_pkg::ACC_W-1:0] base;
  logic signed [gjksr_pkg::ACC_W-1:0] sum;

  always_comb begin
    term  = step[3:1];
    half  = step[0];
    sel   = gjksr_pkg::term_sel(kind_r, term);
    u_sel = u[sel.ui];
    // low half unsigned, high half carries the sign
    part = half ? {u_sel[gjksr_pkg::WIDE_W-1], u_sel[gjksr_pkg::WIDE_W-1:gjksr_pkg::PART_W]}
                : {1'b0, u_sel[gjksr_pkg::PART_W-1:0]};
    prod_next = part * v[sel.vi];
    if (kind_r == gjksr_pkg::VU_CROSS) begin
      g_first      = !term[0] && !half;
      g_last       = term[0] && half;
      g_final      = (term == 3'd5);
      is_last_step = (step == LAST_CROSS);
    end else begin
      g_first      = (term == 3'd0) && !half;
      g_last       = (term == 3'd2) && half;
      g_final      = (term == 3'd2);
      is_last_step = (step == LAST_DOT);
    end
  end

  always_comb begin
    ext    = gjksr_pkg::ACC_W'(p_prod);
    addend = p_shift ? (ext <<< gjksr_pkg::PART_W) : ext;
    base   = p_first ? '0 : acc;
    sum    = p_sub ? (base - addend) : (base + addend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      p_valid <= 1'b0;
      done_r  <= 1'b0;
      step    <= '0;
    end else begin
      p_valid <= busy;
      done_r  <= p_valid && p_final && p_last;
      if (busy) begin
        step <= step + 4'd1;
        if (is_last_step) begin
          busy <= 1'b0;
        end
      end else if (ctrl.start) begin
        busy <= 1'b1;
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && ctrl.start) begin
      kind_r <= ctrl.kind;
      neg_r  <= ctrl.neg;
    end
    p_prod  <= prod_next;
    p_first <= g_first;
    p_last  <= g_last;
    p_final <= g_final;
    p_shift <= half;
    p_sub   <= sel.sub ^ neg_r;
    p_comp  <= term[2:1];
    if (p_valid) begin
      acc <= sum;
      if (p_last) begin
        res_r[p_comp] <= sum[gjksr_pkg::WIDE_W-1:0];
        pos_r         <= !sum[gjksr_pkg::ACC_W-1] && (sum != '0);
      end
    end
  end

  assign stat.done = done_r;
  assign stat.pos  = pos_r;
  assign res       = res_r;

endmodule

`default_nettype wire

>>> src/gjk_simplex_refine_core.sv
// top level of the gjk simplex refine core: sequencer, simplex and direction state
// usage
//   request channel: req_valid / req_stall / req_data. op start seeds the simplex
//   with the support point; op next reports the support point the host found
//   along the last direction. request accepted when req_valid high, req_stall low
//   response channel: rsp_valid / rsp_stall / rsp_data, one response per request
//   config channel: cfg_valid / cfg_ready / cfg_data writes max_iterations,
//   cfg_ready always high, write only while no request is in flight
// request flow
//   one request at a time; req_stall is high from acceptance until the response
//   is loaded. the one shared 28x18 multiplier does two partial products per
//   term, and a cross or dot product holds the sequencer until it is done
// reset
//   synchronous, active high; max_iterations returns to 32, the simplex is
//   empty and the core awaits a start request
// back pressure
//   the response sits in an output register; a new request is taken while it
//   waits, and the core holds the next result until rsp_stall drops
`default_nettype none

`include "gjk_simplex_refine_core_defines.svh"

module gjk_simplex_refine_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  gjksr_pkg::req_t     req_data,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output gjksr_pkg::rsp_t     rsp_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [gjksr_pkg::IT_W-1:0] cfg_data
);

  localparam int unsigned SH = gjksr_pkg::COORD_W - COORD_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK,
    S_LINE_DOT, S_LINE_X1, S_LINE_X2,
    S_TRI_X0, S_TRI_X1, S_TRI_D1, S_TRI_D2, S_TRI_X2, S_TRI_X3,
    S_TRI_X4, S_TRI_D3, S_TRI_D4,
    S_TET_X, S_TET_D,
    S_EMIT
  } state_t;

  state_t                        state;
  logic                          issued;
  logic [1:0]                    face;

  // simplex, newest point first
  gjksr_pkg::point_t             pts [4];
  logic [gjksr_pkg::CNT_W-1:0]   count;
  gjksr_pkg::wide_vec_t          dir;
  gjksr_pkg::wide_vec_t          nrm;
  gjksr_pkg::wide_vec_t          tmp;
  gjksr_pkg::point_t             p_hold;
  logic [gjksr_pkg::IT_W-1:0]    iter;
  logic [gjksr_pkg::IT_W-1:0]    max_it;
  logic                          finished;

  // pending response fields
  logic [1:0]                    em_status;
  logic                          em_limit;
  logic                          em_zero;

  gjksr_pkg::point_t             p_in;
  gjksr_pkg::nar_vec_t           vb;
  gjksr_pkg::nar_vec_t           vc;
  gjksr_pkg::nar_vec_t           ao;
  gjksr_pkg::nar_vec_t           pn;
  gjksr_pkg::wide_vec_t          wb;
  gjksr_pkg::wide_vec_t          wc;
  gjksr_pkg::wide_vec_t          ao_w;
  gjksr_pkg::wide_vec_t          p_neg;
  gjksr_pkg::wide_vec_t          nrm_neg;
  logic [gjksr_pkg::CNT_W-1:0]   cnt_inc;
  logic [1:0]                    lim_status;

  gjksr_pkg::vu_ctrl_t           vu_ctrl;
  gjksr_pkg::vu_stat_t           vu_stat;
  gjksr_pkg::wide_vec_t          vu_u;
  gjksr_pkg::nar_vec_t           vu_v;
  gjksr_pkg::wide_vec_t          vu_res;

  // only the low COORD_BITS of each coordinate count, sign extended
  always_comb begin
    p_in[0] = (req_data.point_x <<< SH) >>> SH;
    p_in[1] = (req_data.point_y <<< SH) >>> SH;
    p_in[2] = (req_data.point_z <<< SH) >>> SH;
  end

  // edge vectors from the newest point a: ab, ac and a to origin
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vb[i]      = gjksr_pkg::nar_t'(pts[1][i]) - gjksr_pkg::nar_t'(pts[0][i]);
      vc[i]      = gjksr_pkg::nar_t'(pts[2][i]) - gjksr_pkg::nar_t'(pts[0][i]);
      ao[i]      = -gjksr_pkg::nar_t'(pts[0][i]);
      pn[i]      = gjksr_pkg::nar_t'(p_hold[i]);
      wb[i]      = gjksr_pkg::wide_t'(vb[i]);
      wc[i]      = gjksr_pkg::wide_t'(vc[i]);
      ao_w[i]    = gjksr_pkg::wide_t'(ao[i]);
      p_neg[i]   = -gjksr_pkg::wide_t'(p_in[i]);
      nrm_neg[i] = -nrm[i];
    end
    cnt_inc    = (count == 3'd4) ? 3'd4 : (count + 3'd1);
    lim_status = (em_limit && (iter >= max_it)) ? gjksr_pkg::ST_MISS : em_status;
  end

  // operand routing for the shared unit, one product per sequencer step
  always_comb begin
    vu_ctrl.kind = gjksr_pkg::VU_DOT;
    vu_ctrl.neg  = 1'b0;
    vu_u         = dir;
    vu_v         = pn;
    unique case (state)
      S_CHECK: begin
        vu_u = dir;
        vu_v = pn;
      end
      S_LINE_DOT: begin
        vu_u = wb;
        vu_v = ao;
      end
      S_LINE_X1: begin
        vu_ctrl.kind = gjksr_pkg::VU_CROSS;
        vu_u         = wb;
        vu_v         = ao;
      end
      S_LINE_X2: begin
        vu_ctrl.kind = gjksr_pkg::VU_CROSS;
        vu_u         = tmp;
        vu_v         = vb;
      end
      S_TRI_X0, S_TET_X: begin
        vu_ctrl.kind = gjksr_pkg::VU_CROSS;
        vu_u         = wb;
        vu_v         = vc;
      end
      S_TRI_X1: begin
        vu_ctrl.kind = gjksr_pkg::VU_CROSS;
        vu_u         = nrm;
        vu_v         = vc;
      end
      S_TRI_D1, S_TRI_D3: begin
        vu_u = tmp;
        vu_v = ao;
      end
      S_TRI_D2: begin
        vu_u = wc;
        vu_v = ao;
      end
      S_TRI_X2: begin
        vu_ctrl.kind = gjksr_pkg::VU_CROSS;
        vu_u         = wc;
        vu_v         = ao;
      end
      S_TRI_X3: begin
        vu_ctrl.kind = gjksr_pkg::VU_CROSS;
        vu_u         = tmp;
        vu_v         = vc;
      end
      // ab x abc taken as -(abc x ab)
      S_TRI_X4: begin
        vu_ctrl.kind = gjksr_pkg::VU_CROSS;
        vu_ctrl.neg  = 1'b1;
        vu_u         = nrm;
        vu_v         = vb;
      end
      S_TRI_D4, S_TET_D: begin
        vu_u = nrm;
        vu_v = ao;
      end
      default: begin
        vu_u = dir;
        vu_v = pn;
      end
    endcase
    vu_ctrl.start = (state != S_IDLE) && (state != S_EMIT) && !issued;
  end

  gjksr_vec_unit u_vec (
    .clk  (clk),
    .rst  (rst),
    .ctrl (vu_ctrl),
    .u    (vu_u),
    .v    (vu_v),
    .stat (vu_stat),
    .res  (vu_res)
  );

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      count     <= '0;
      iter      <= '0;
      finished  <= 1'b1;
      max_it    <= gjksr_pkg::MAX_IT_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_it <= cfg_data;
      end
      // a response taken while a new one loads is handled in the emit state
      if (rsp_valid && !rsp_stall && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      if (vu_stat.done) begin
        issued <= 1'b0;
      end else if (vu_ctrl.start) begin
        issued <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            em_zero  <= 1'b0;
            em_limit <= 1'b0;
            if (req_data.op == gjksr_pkg::OP_START) begin
              // restart from the new point, search toward the origin
              pts[0]    <= p_in;
              count     <= 3'd1;
              dir       <= p_neg;
              iter      <= '0;
              finished  <= 1'b0;
              em_status <= gjksr_pkg::ST_CONT;
              state     <= S_EMIT;
            end else if (finished) begin
              em_status <= gjksr_pkg::ST_IGNORED;
              em_zero   <= 1'b1;
              state     <= S_EMIT;
            end else begin
              p_hold <= p_in;
              state  <= S_CHECK;
            end
          end
        end

        // support point must pass the origin along the direction
        S_CHECK: begin
          if (vu_stat.done) begin
            if (!vu_stat.pos) begin
              em_status <= gjksr_pkg::ST_MISS;
              finished  <= 1'b1;
              state     <= S_EMIT;
            end else begin
              pts[3]    <= pts[2];
              pts[2]    <= pts[1];
              pts[1]    <= pts[0];
              pts[0]    <= p_hold;
              count     <= cnt_inc;
              iter      <= iter + 8'd1;
              em_status <= gjksr_pkg::ST_CONT;
              em_limit  <= 1'b1;
              face      <= 2'd0;
              priority if (cnt_inc == 3'd2) begin
                state <= S_LINE_DOT;
              end else if (cnt_inc == 3'd3) begin
                state <= S_TRI_X0;
              end else begin
                state <= S_TET_X;
              end
            end
          end
        end

        S_LINE_DOT: begin
          if (vu_stat.done) begin
            if (vu_stat.pos) begin
              count <= 3'd2;
              state <= S_LINE_X1;
            end else begin
              count <= 3'd1;
              dir   <= ao_w;
              state <= S_EMIT;
            end
          end
        end

        S_LINE_X1: begin
          if (vu_stat.done) begin
            tmp   <= vu_res;
            state <= S_LINE_X2;
          end
        end

        S_LINE_X2: begin
          if (vu_stat.done) begin
            dir   <= vu_res;
            state <= S_EMIT;
          end
        end

        S_TRI_X0: begin
          if (vu_stat.done) begin
            nrm   <= vu_res;
            state <= S_TRI_X1;
          end
        end

        S_TRI_X1: begin
          if (vu_stat.done) begin
            tmp   <= vu_res;
            state <= S_TRI_D1;
          end
        end

        // origin beyond edge ac
        S_TRI_D1: begin
          if (vu_stat.done) begin
            state <= vu_stat.pos ? S_TRI_D2 : S_TRI_X4;
          end
        end

        S_TRI_D2: begin
          if (vu_stat.done) begin
            if (vu_stat.pos) begin
              pts[1] <= pts[2];
              count  <= 3'd2;
              state  <= S_TRI_X2;
            end else begin
              state <= S_LINE_DOT;
            end
          end
        end

        S_TRI_X2: begin
          if (vu_stat.done) begin
            tmp   <= vu_res;
            state <= S_TRI_X3;
          end
        end

        S_TRI_X3: begin
          if (vu_stat.done) begin
            dir   <= vu_res;
            state <= S_EMIT;
          end
        end

        S_TRI_X4: begin
          if (vu_stat.done) begin
            tmp   <= vu_res;
            state <= S_TRI_D3;
          end
        end

        // origin beyond edge ab
        S_TRI_D3: begin
          if (vu_stat.done) begin
            state <= vu_stat.pos ? S_LINE_DOT : S_TRI_D4;
          end
        end

        // origin above or below the triangle, keep winding toward it
        S_TRI_D4: begin
          if (vu_stat.done) begin
            count <= 3'd3;
            if (vu_stat.pos) begin
              dir <= nrm;
            end else begin
              pts[1] <= pts[2];
              pts[2] <= pts[1];
              dir    <= nrm_neg;
            end
            state <= S_EMIT;
          end
        end

        S_TET_X: begin
          if (vu_stat.done) begin
            nrm   <= vu_res;
            state <= S_TET_D;
          end
        end

        // faces abc, acd, adb in turn: rotate b, c, d so the face sits in slots 1 and 2
        S_TET_D: begin
          if (vu_stat.done) begin
            if (vu_stat.pos) begin
              state <= S_TRI_X1;
            end else if (face == 2'd2) begin
              em_status <= gjksr_pkg::ST_HIT;
              em_limit  <= 1'b0;
              finished  <= 1'b1;
              state     <= S_EMIT;
            end else begin
              face   <= face + 2'd1;
              pts[1] <= pts[2];
              pts[2] <= pts[3];
              pts[3] <= pts[1];
              state  <= S_TET_X;
            end
          end
        end

        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid              <= 1'b1;
            rsp_data.dir_x         <= em_zero ? '0 : dir[0][gjksr_pkg::DIR_W-1:0];
            rsp_data.dir_y         <= em_zero ? '0 : dir[1][gjksr_pkg::DIR_W-1:0];
            rsp_data.dir_z         <= em_zero ? '0 : dir[2][gjksr_pkg::DIR_W-1:0];
            rsp_data.status        <= lim_status;
            rsp_data.simplex_count <= count;
            if (em_limit && (iter >= max_it)) begin
              finished <= 1'b1;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GJKSR_ASSERT(a_done_issued, vu_stat.done |-> issued, "product unit finished with nothing issued")
  `GJKSR_ASSERT(a_check_running, (state == S_CHECK) |-> !finished, "support test while search is over")
  `GJKSR_ASSERT(a_accept_busy, (req_valid && !req_stall) |=> (state != S_IDLE), "request accepted but core idle")
  `GJKSR_ASSERT_ALWAYS(a_reset_state, $past(rst) |-> (state == S_IDLE && finished && !rsp_valid), "bad state after reset")

endmodule

`default_nettype wire

>>> verif/gjk_simplex_refine_core_tb.sv
// self-checking testbench for the gjk simplex refine core: host-driven queries, noise, back pressure
`default_nettype none

module gjk_simplex_refine_core_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned REQ_W       = $bits(gjksr_pkg::req_t);

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  function automatic vec3_t vsub(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec3_t vneg(vec3_t a);
    vec3_t r;
    r.x = -a.x;
    r.y = -a.y;
    r.z = -a.z;
    return r;
  endfunction

  function automatic vec3_t vcross(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // exact dot product on 128 bits
  function automatic logic signed [127:0] vdot(vec3_t u, vec3_t v);
    logic signed [127:0] ux, uy, uz, vx, vy, vz;
    ux = u.x;
    uy = u.y;
    uz = u.z;
    vx = v.x;
    vy = v.y;
    vz = v.z;
    return ux * vx + uy * vy + uz * vz;
  endfunction

  function automatic bit points_along(vec3_t u, vec3_t v);
    return vdot(u, v) > 0;
  endfunction

  // predicts the core's simplex refinement and holds the responses still due
  class refine_scoreboard;
    vec3_t             simplex [4];
    int unsigned       held;
    vec3_t             dir;
    int unsigned       iters;
    bit                finished;
    int unsigned       max_iters;
    gjksr_pkg::rsp_t   awaited [$];
    int                errors;

    function new();
      for (int i = 0; i < 4; i++) simplex[i] = '0;
      dir = '0;
      held = 0;
      iters = 0;
      finished = 1'b1;
      max_iters = gjksr_pkg::MAX_IT_RESET;
      errors = 0;
    endfunction

    function void reduce_line(vec3_t a, vec3_t b);
      vec3_t ab, ao;
      ab = vsub(b, a);
      ao = vneg(a);
      simplex[0] = a;
      if (points_along(ab, ao)) begin
        simplex[1] = b;
        held = 2;
        dir = vcross(vcross(ab, ao), ab);
      end else begin
        held = 1;
        dir = ao;
      end
    endfunction

    function void reduce_triangle(vec3_t a, vec3_t b, vec3_t c);
      vec3_t ab, ac, ao, abc;
      ab = vsub(b, a);
      ac = vsub(c, a);
      ao = vneg(a);
      abc = vcross(ab, ac);
      if (points_along(vcross(abc, ac), ao)) begin
        if (points_along(ac, ao)) begin
          simplex[0] = a;
          simplex[1] = c;
          held = 2;
          dir = vcross(vcross(ac, ao), ac);
        end else begin
          reduce_line(a, b);
        end
      end else if (points_along(vcross(ab, abc), ao)) begin
        reduce_line(a, b);
      end else begin
        simplex[0] = a;
        held = 3;
        if (points_along(abc, ao)) begin
          simplex[1] = b;
          simplex[2] = c;
          dir = abc;
        end else begin
          simplex[1] = c;
          simplex[2] = b;
          dir = vneg(abc);
        end
      end
    endfunction

    // true when the tetrahedron encloses the origin
    function bit reduce_tetra();
      vec3_t a, b, c, d, ab, ac, ad, ao;
      a = simplex[0];
      b = simplex[1];
      c = simplex[2];
      d = simplex[3];
      ab = vsub(b, a);
      ac = vsub(c, a);
      ad = vsub(d, a);
      ao = vneg(a);
      if (points_along(vcross(ab, ac), ao)) begin
        reduce_triangle(a, b, c);
        return 1'b0;
      end
      if (points_along(vcross(ac, ad), ao)) begin
        reduce_triangle(a, c, d);
        return 1'b0;
      end
      if (points_along(vcross(ad, ab), ao)) begin
        reduce_triangle(a, d, b);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(gjksr_pkg::req_t r);
      vec3_t           p;
      gjksr_pkg::rsp_t e;
      logic [1:0]      st;
      bit              hit;
      p.x = r.point_x;
      p.y = r.point_y;
      p.z = r.point_z;
      st = gjksr_pkg::ST_CONT;
      hit = 1'b0;
      if (r.op == gjksr_pkg::OP_START) begin
        simplex[0] = p;
        held = 1;
        dir = vneg(p);
        iters = 0;
        finished = 1'b0;
      end else if (finished) begin
        st = gjksr_pkg::ST_IGNORED;
      end else if (!points_along(p, dir)) begin
        finished = 1'b1;
        st = gjksr_pkg::ST_MISS;
      end else begin
        simplex[3] = simplex[2];
        simplex[2] = simplex[1];
        simplex[1] = simplex[0];
        simplex[0] = p;
        if (held < 4) held++;
        iters = (iters + 1) & 255;
        if (held == 2) reduce_line(simplex[0], simplex[1]);
        else if (held == 3) reduce_triangle(simplex[0], simplex[1], simplex[2]);
        else if (held == 4) hit = reduce_tetra();
        if (hit) begin
          st = gjksr_pkg::ST_HIT;
          finished = 1'b1;
        end else if (iters >= max_iters) begin
          st = gjksr_pkg::ST_MISS;
          finished = 1'b1;
        end
      end
      if (st == gjksr_pkg::ST_IGNORED) begin
        e.dir_x = '0;
        e.dir_y = '0;
        e.dir_z = '0;
      end else begin
        e.dir_x = dir.x[gjksr_pkg::DIR_W-1:0];
        e.dir_y = dir.y[gjksr_pkg::DIR_W-1:0];
        e.dir_z = dir.z[gjksr_pkg::DIR_W-1:0];
      end
      e.status = st;
      e.simplex_count = held[gjksr_pkg::CNT_W-1:0];
      awaited = {awaited, e};
    endfunction

    function void check_result(gjksr_pkg::rsp_t got);
      gjksr_pkg::rsp_t e;
      if (awaited.size() == 0) begin
        $error("response with none awaited: status %0d", got.status);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.dir_x !== e.dir_x) begin
        $error("dir_x expected %0d actual %0d", e.dir_x, got.dir_x);
        errors++;
      end
      if (got.dir_y !== e.dir_y) begin
        $error("dir_y expected %0d actual %0d", e.dir_y, got.dir_y);
        errors++;
      end
      if (got.dir_z !== e.dir_z) begin
        $error("dir_z expected %0d actual %0d", e.dir_z, got.dir_z);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
      if (got.simplex_count !== e.simplex_count) begin
        $error("simplex_count expected %0d actual %0d", e.simplex_count, got.simplex_count);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         req_valid;
  logic                         req_stall;
  gjksr_pkg::req_t              req_data;
  logic                         rsp_valid;
  logic                         rsp_stall;
  gjksr_pkg::rsp_t              rsp_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [gjksr_pkg::IT_W-1:0]   cfg_data;

  refine_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_start = 1'b0;

  // host side convex point cloud, the support query picks from it
  vec3_t cloud [8];

  gjk_simplex_refine_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gjk_simplex_refine_core regression: fail");
      $finish;
    end
  end

  // response side: random stalls, plus one long hold-off to back the core up
  always @(negedge clk) begin
    if (hold_start) begin
      hold_left = 400;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // responses are sampled at the rising edge they are taken on
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
  end

  function automatic gjksr_pkg::req_t mk_req(logic op, vec3_t p);
    gjksr_pkg::req_t r;
    r.op = op;
    r.point_x = 16'(p.x);
    r.point_y = 16'(p.y);
    r.point_z = 16'(p.z);
    return r;
  endfunction

  function automatic vec3_t mk_vec(longint x, longint y, longint z);
    vec3_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  // farthest cloud point along d
  function automatic vec3_t support(vec3_t d);
    vec3_t best;
    best = cloud[0];
    for (int i = 1; i < 8; i++) if (vdot(cloud[i], d) > vdot(best, d)) best = cloud[i];
    return best;
  endfunction

  // one request; valid stays high across back-to-back requests
  task automatic send_request(gjksr_pkg::req_t r);
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_request(r);
    sent++;
  endtask

  task automatic send_noise();
    gjksr_pkg::req_t r;
    r = gjksr_pkg::req_t'(REQ_W'({$urandom, $urandom}));
    send_request(r);
  endtask

  // a full query the way a host runs it, with the odd stray point
  task automatic run_query();
    for (int k = 0; k < 40 && !sb.finished; k++) begin
      if ($urandom_range(99) < 4) send_noise();
      else send_request(mk_req(gjksr_pkg::OP_NEXT, support(sb.dir)));
    end
    if ($urandom_range(99) < 15) send_request(mk_req(gjksr_pkg::OP_NEXT, support(sb.dir)));
  endtask

  task automatic start_query();
    send_request(mk_req(gjksr_pkg::OP_START, support(mk_vec(1, 0, 0))));
    run_query();
  endtask

  // cloud near the origin half the time, so hits are common
  task automatic build_cloud();
    int rad, cx, cy, cz, span;
    rad = ($urandom_range(9) == 0) ? 32767 : $urandom_range(50, 3000);
    span = ($urandom_range(1) == 0) ? rad / 3 : 32767 - rad;
    cx = int'($urandom_range(2 * span)) - span;
    cy = int'($urandom_range(2 * span)) - span;
    cz = int'($urandom_range(2 * span)) - span;
    for (int i = 0; i < 8; i++) begin
      cloud[i] = mk_vec(cx + int'($urandom_range(2 * rad)) - rad,
                        cy + int'($urandom_range(2 * rad)) - rad,
                        cz + int'($urandom_range(2 * rad)) - rad);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // max_iterations write, only with the core idle
  task automatic write_max_iters(logic [gjksr_pkg::IT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.max_iters = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned cfg_vals [4];
    int unsigned idle_vals [4];
    int unsigned stall_vals [4];
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: next before any start is ignored
    send_request(mk_req(gjksr_pkg::OP_NEXT, mk_vec(5, 5, 5)));
    // start at the origin gives a zero direction, so the next point misses
    send_request(mk_req(gjksr_pkg::OP_START, mk_vec(0, 0, 0)));
    send_request(mk_req(gjksr_pkg::OP_NEXT, mk_vec(1, 1, 1)));
    // ignored once finished
    send_request(mk_req(gjksr_pkg::OP_NEXT, mk_vec(-1, -1, -1)));
    // coordinate extremes
    send_request(mk_req(gjksr_pkg::OP_START, mk_vec(-32768, -32768, -32768)));
    send_request(mk_req(gjksr_pkg::OP_NEXT, mk_vec(32767, 32767, 32767)));
    // restart while running
    send_request(mk_req(gjksr_pkg::OP_START, mk_vec(32767, -32768, 0)));
    send_request(mk_req(gjksr_pkg::OP_NEXT, mk_vec(-32768, 32767, -1)));
    send_request(mk_req(gjksr_pkg::OP_NEXT, mk_vec(-32768, -32768, 32767)));
    // tetrahedron around the origin drives line, triangle and hit cases
    cloud[0] = mk_vec(1000, -1000, -1000);
    cloud[1] = mk_vec(-1000, 1000, -1000);
    cloud[2] = mk_vec(-1000, -1000, 1000);
    cloud[3] = mk_vec(1000, 1000, 1000);
    for (int i = 4; i < 8; i++) cloud[i] = cloud[i - 4];
    start_query();

    cfg_vals = '{255, 1, 32, $urandom_range(2, 254)};
    idle_vals = '{0, 53, 0, 25};
    stall_vals = '{0, 0, 53, 25};
    for (int ph = 0; ph < 4; ph++) begin
      write_max_iters(cfg_vals[ph][gjksr_pkg::IT_W-1:0]);
      send_idle_pct = idle_vals[ph];
      stall_pct = stall_vals[ph];
      if (ph == 2) hold_start = 1'b1;
      while (sent < (ph + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          build_cloud();
          start_query();
        end else begin
          send_noise();
        end
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("gjk_simplex_refine_core regression: pass");
    end else begin
      $display("gjk_simplex_refine_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> gjk_simplex_refine_core.f
+incdir+src
src/gjksr_pkg.sv
src/gjksr_vec_unit.sv
src/gjk_simplex_refine_core.sv
verif/gjk_simplex_refine_core_tb.sv
